>>> hw/rtl/qth_pkg.sv
// ----------------------------------------------------------------------------
// qth_pkg: shared types and constants for the quaternion heading block
// Operand widths, queue entry layout and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qth_pkg;

  // Exact operand widths: x = qi^2 - qj^2 - qk^2 + qr^2, y = 2(qi*qj + qk*qr)
  localparam int unsigned PRODW = 32;
  localparam int unsigned XW    = 33;
  localparam int unsigned YW    = 34;
  // CORDIC datapath: operand growth of ~1.65 plus the 180 degree pre-turn
  localparam int unsigned DW    = 36;
  // Angle accumulator in 2^-16 degree units
  localparam int unsigned ZW    = 26;
  // z * 100 + half, before the shift to centidegrees
  localparam int unsigned PW    = 33;
  localparam int unsigned CW    = 18;

  localparam logic signed [ZW-1:0] ANGLE_180  = ZW'(180 * 65536);
  localparam logic signed [PW-1:0] CENTI_MUL  = PW'(100);
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);
  localparam logic signed [CW-1:0] FULL_TURN  = CW'(36000);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
    logic [1:0]           status;
  } qth_item_t;

  // front -> queue write request
  typedef struct packed {
    logic      valid;
    qth_item_t item;
  } qth_push_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest; zero past step 22
  function automatic logic signed [ZW-1:0] atan_angle(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = ZW'(2949120);
      1:       a = ZW'(1740967);
      2:       a = ZW'(919879);
      3:       a = ZW'(466945);
      4:       a = ZW'(234379);
      5:       a = ZW'(117304);
      6:       a = ZW'(58666);
      7:       a = ZW'(29335);
      8:       a = ZW'(14668);
      9:       a = ZW'(7334);
      10:      a = ZW'(3667);
      11:      a = ZW'(1833);
      12:      a = ZW'(917);
      13:      a = ZW'(458);
      14:      a = ZW'(229);
      15:      a = ZW'(115);
      16:      a = ZW'(57);
      17:      a = ZW'(29);
      18:      a = ZW'(14);
      19:      a = ZW'(7);
      20:      a = ZW'(4);
      21:      a = ZW'(2);
      22:      a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> hw/rtl/qth_front.sv
// ----------------------------------------------------------------------------
// qth_front: request intake
// Filters by report identifier, registers the quaternion products and
// pushes the exact atan2 operands into the queue.
// ----------------------------------------------------------------------------
module qth_front #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned LW    = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          report_id_i,
  input  logic signed [15:0]  q_real_i,
  input  logic signed [15:0]  q_i_i,
  input  logic signed [15:0]  q_j_i,
  input  logic signed [15:0]  q_k_i,
  input  logic [1:0]          status_i,
  input  logic [7:0]          rotation_id_i,
  input  logic [LW-1:0]       level_i,
  output qth_pkg::qth_push_t  push_o
);
  import qth_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [PRODW-1:0] p_ij_q, p_kr_q, p_ii_q, p_jj_q, p_kk_q, p_rr_q;
  logic [1:0]              status_q;
  logic                    accept;

  // one slot in flight here, so hold off one entry early
  assign busy = (level_i >= LW'(DEPTH)) || (valid_q && (level_i >= LW'(DEPTH - 1)));
  assign accept  = start && !busy;
  assign valid_d = accept && (report_id_i == rotation_id_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      p_ij_q   <= q_i_i * q_j_i;
      p_kr_q   <= q_k_i * q_real_i;
      p_ii_q   <= q_i_i * q_i_i;
      p_jj_q   <= q_j_i * q_j_i;
      p_kk_q   <= q_k_i * q_k_i;
      p_rr_q   <= q_real_i * q_real_i;
      status_q <= status_i;
    end
  end

  always_comb begin
    push_o.valid       = valid_q;
    push_o.item.x      = XW'(p_ii_q) - XW'(p_jj_q) - XW'(p_kk_q) + XW'(p_rr_q);
    push_o.item.y      = (YW'(p_ij_q) + YW'(p_kr_q)) <<< 1;
    push_o.item.status = status_q;
  end

endmodule

>>> hw/rtl/qth_queue.sv
// ----------------------------------------------------------------------------
// qth_queue: operand queue
// Small FIFO between intake and the CORDIC engine.
// ----------------------------------------------------------------------------
module qth_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned LW    = 3,
  parameter int unsigned PTRW  = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qth_pkg::qth_push_t  push_i,
  input  logic                pop_i,
  output logic                not_empty_o,
  output qth_pkg::qth_item_t  head_o,
  output logic [LW-1:0]       level_o
);
  import qth_pkg::*;

  qth_item_t       mem_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]   level_q, level_d;
  logic            do_pop;

  assign do_pop      = pop_i && (level_q != '0);
  assign not_empty_o = (level_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign level_o     = level_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (!push_i.valid && do_pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

>>> hw/rtl/qth_cordic.sv
// ----------------------------------------------------------------------------
// qth_cordic: vectoring CORDIC engine
// One micro-rotation per cycle, then scaling to centidegrees and wrapping.
// ----------------------------------------------------------------------------
module qth_cordic #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned SW           = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                not_empty_i,
  input  qth_pkg::qth_item_t  head_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output logic [15:0]         heading_centideg_o,
  output logic [1:0]          accuracy_o
);
  import qth_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [SW-1:0]        cnt_q, cnt_d;
  logic signed [DW-1:0] x_q, x_d, y_q, y_d, xs, ys, x_in, y_in;
  logic signed [ZW-1:0] z_q, z_d, a;
  logic                 zero_q, zero_d;
  logic [1:0]           status_q, status_d;
  logic                 valid_q, valid_d;
  logic [15:0]          heading_q, heading_d;
  logic [1:0]           accuracy_q, accuracy_d;
  logic signed [PW-1:0] scaled;
  logic signed [CW-1:0] c0, c1, c2;
  logic                 load;

  assign load = not_empty_i && ((state_q == S_IDLE) || (state_q == S_DONE));
  assign pop_o = load;

  assign x_in = DW'(head_i.x);
  assign y_in = DW'(head_i.y);
  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;
  assign a    = atan_angle(32'(cnt_q));

  // centidegrees = floor((z * 100 + 32768) / 65536), then wrap
  assign scaled = (PW'(z_q) * CENTI_MUL) + ROUND_HALF;
  always_comb begin
    c0 = CW'(scaled >>> 16);
    c1 = (c0 < 0) ? c0 + FULL_TURN : c0;
    if (c1 < 0) begin
      c1 = '0;
    end
    c2 = (c1 >= FULL_TURN) ? c1 - FULL_TURN : c1;
    if (c2 >= FULL_TURN) begin
      c2 = '0;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    zero_d     = zero_q;
    status_d   = status_q;
    valid_d    = 1'b0;
    heading_d  = heading_q;
    accuracy_d = accuracy_q;

    case (state_q)
      S_IDLE: begin
      end
      S_RUN: begin
        if (y_q < 0) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - a;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + a;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SW'(CORDIC_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        valid_d    = 1'b1;
        heading_d  = zero_q ? 16'd0 : c2[15:0];
        accuracy_d = status_q;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      state_d  = S_RUN;
      cnt_d    = '0;
      zero_d   = (x_in == 0) && (y_in == 0);
      status_d = head_i.status;
      if (x_in < 0) begin
        // turn by 180 degrees into the right half plane
        x_d = -x_in;
        y_d = -y_in;
        z_d = (y_in >= 0) ? ANGLE_180 : -ANGLE_180;
      end else begin
        x_d = x_in;
        y_d = y_in;
        z_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    zero_q     <= zero_d;
    status_q   <= status_d;
    heading_q  <= heading_d;
    accuracy_q <= accuracy_d;
  end

  assign result_valid_o     = valid_q;
  assign heading_centideg_o = heading_q;
  assign accuracy_o         = accuracy_q;

endmodule

>>> hw/rtl/quaternion_to_heading.sv
// ----------------------------------------------------------------------------
// quaternion_to_heading: yaw heading from a rotation vector report
// Throughput: the single CORDIC engine does one micro-rotation per cycle
//   and takes a new request only once done with the last; intake buffers
//   up to QUEUE_DEPTH requests. The receiver cannot stall the strobe.
// Reset: asynchronous, active low; clears queue and engine, rotation_id = 5.
// ----------------------------------------------------------------------------
module quaternion_to_heading #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         report_id_i,
  input  logic signed [15:0] q_real_i,
  input  logic signed [15:0] q_i_i,
  input  logic signed [15:0] q_j_i,
  input  logic signed [15:0] q_k_i,
  input  logic [1:0]         status_i,
  // rotation_id register
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  // result strobe
  output logic               result_valid_o,
  output logic [15:0]        heading_centideg_o,
  output logic [1:0]         accuracy_o
);
  import qth_pkg::*;

  localparam int unsigned LW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned SW   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic [7:0]    rotation_id_q;
  qth_push_t     push;
  qth_item_t     head;
  logic          not_empty;
  logic          pop;
  logic [LW-1:0] level;

  // Only reports carrying this identifier produce a heading.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_id_q <= 8'd5;
    end else if (cfg_we_i) begin
      rotation_id_q <= cfg_wdata_i;
    end
  end

  // Front: filter, multiply, form the atan2 operands exactly.
  qth_front #(
    .DEPTH (QUEUE_DEPTH),
    .LW    (LW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .report_id_i   (report_id_i),
    .q_real_i      (q_real_i),
    .q_i_i         (q_i_i),
    .q_j_i         (q_j_i),
    .q_k_i         (q_k_i),
    .status_i      (status_i),
    .rotation_id_i (rotation_id_q),
    .level_i       (level),
    .push_o        (push)
  );

  // Decouples intake from the multi-cycle engine.
  qth_queue #(
    .DEPTH (QUEUE_DEPTH),
    .LW    (LW),
    .PTRW  (PTRW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head),
    .level_o     (level)
  );

  // Back: iterative vectoring CORDIC plus centidegree conversion.
  qth_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SW           (SW)
  ) u_cordic (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .not_empty_i        (not_empty),
    .head_i             (head),
    .pop_o              (pop),
    .result_valid_o     (result_valid_o),
    .heading_centideg_o (heading_centideg_o),
    .accuracy_o         (accuracy_o)
  );

  // heading is always wrapped into a single turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (heading_centideg_o < 16'd36000))
    else $error("heading out of range");

  // the engine finishes at most one request per strobe cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // busy must keep the queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && !pop) |-> (level < LW'(QUEUE_DEPTH)))
    else $error("queue overflow");

  // a request with a foreign identifier never reaches the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (report_id_i != rotation_id_q)) |=> !push.valid)
    else $error("filtered request entered the queue");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking regression for quaternion_to_heading
// Drives rotation vector reports through the command port, predicts the
// wrapped yaw heading of every matching report with a bit-exact CORDIC
// model, and checks each result strobe in order against the prediction.
// ----------------------------------------------------------------------------
module tb;

  // Matches the DUT default; passed down so model and RTL agree.
  localparam int HDG_STEPS   = 16;
  localparam int QDEPTH      = 4;
  // Settling margin, sized for a full intake queue plus a pass through the
  // engine; requests that give no strobe are dropped at intake.
  localparam int SETTLE      = (QDEPTH + 1) * (HDG_STEPS + 1) + HDG_STEPS + 8;
  // Cycles without any accepted request or result before giving up.
  localparam int STALL_LIMIT = 4000;
  localparam int IDLE_PCT    = 28;
  localparam logic [7:0] RID_RESET = 8'd5;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  localparam longint ATAN_LUT [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic [7:0]         rid;
    logic signed [15:0] qr;
    logic signed [15:0] qi;
    logic signed [15:0] qj;
    logic signed [15:0] qk;
    logic [1:0]         st;
  } report_t;

  typedef struct {
    logic [15:0] heading;
    logic [1:0]  acc;
  } heading_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               req_start    = 1'b0;
  logic               uut_busy;
  logic [7:0]         report_id    = '0;
  logic signed [15:0] q_real       = '0;
  logic signed [15:0] q_i          = '0;
  logic signed [15:0] q_j          = '0;
  logic signed [15:0] q_k          = '0;
  logic [1:0]         status       = '0;
  logic               cfg_we       = 1'b0;
  logic [7:0]         cfg_wdata    = '0;
  logic               hdg_valid;
  logic [15:0]        hdg_centideg;
  logic [1:0]         hdg_acc;

  report_t  pending_reports[$];
  heading_t expected_headings[$];
  logic [7:0] rotation_id = RID_RESET;  // shadow of the DUT register
  logic       req_taken   = 1'b0;       // request accepted at last rising edge
  bit         steady      = 1'b0;       // no idle cycles while set
  int         errors      = 0;
  int         quiet_cycles = 0;

  quaternion_to_heading #(
    .CORDIC_STEPS (HDG_STEPS),
    .QUEUE_DEPTH  (QDEPTH)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (req_start),
    .busy               (uut_busy),
    .report_id_i        (report_id),
    .q_real_i           (q_real),
    .q_i_i              (q_i),
    .q_j_i              (q_j),
    .q_k_i              (q_k),
    .status_i           (status),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .result_valid_o     (hdg_valid),
    .heading_centideg_o (hdg_centideg),
    .accuracy_o         (hdg_acc)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Yaw of the quaternion in centidegrees, 0..35999.
  // Operands are exact; vectoring CORDIC with floor shifts; z in 2^-16 deg.
  function automatic logic [15:0] yaw_heading(input logic signed [15:0] qr,
                                              input logic signed [15:0] qi,
                                              input logic signed [15:0] qj,
                                              input logic signed [15:0] qk);
    longint r, a, b, c, x, y, z, xs, ys, cd;
    r = qr;
    a = qi;
    b = qj;
    c = qk;
    y = 2 * (a * b + c * r);
    x = a * a - b * b - c * c + r * r;
    z = 0;
    // degenerate vector: no direction, heading defined as 0
    if (x == 0 && y == 0) return 16'd0;
    // left half plane: pre-turn by 180, sign picked from y (y = 0 -> +180)
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < HDG_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_LUT[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_LUT[i];
      end
    end
    // round half up to centidegrees, then fold into one turn
    cd = (z * 100 + 32768) >>> 16;
    if (cd < 0) cd = cd + 36000;
    if (cd < 0) cd = 0;
    if (cd >= 36000) cd = cd - 36000;
    if (cd >= 36000) cd = 0;
    return cd[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: presents the next pending report at the falling edge once
  // the previous request has been taken; random idle cycles unless steady.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    report_t nxt;
    if (rst_ni && (!req_start || req_taken)) begin
      if (pending_reports.size() != 0 &&
          (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_reports.pop_front();
        req_start <= 1'b1;
        report_id <= nxt.rid;
        q_real    <= nxt.qr;
        q_i       <= nxt.qi;
        q_j       <= nxt.qj;
        q_k       <= nxt.qk;
        status    <= nxt.st;
      end else begin
        req_start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each accepted matching request, checks each
  // result strobe against the oldest prediction, runs the stall watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    heading_t want;
    logic     accepted;
    accepted = req_start && !uut_busy;
    req_taken <= accepted;
    if (rst_ni) begin
      // only reports tagged with the configured id produce a heading
      if (accepted && report_id == rotation_id) begin
        want.heading = yaw_heading(q_real, q_i, q_j, q_k);
        want.acc     = status;
        expected_headings.push_back(want);
      end
      if (hdg_valid) begin
        if (expected_headings.size() == 0) begin
          $display("%0t: unexpected result: expected none actual heading %0d accuracy %0d",
                   $time, hdg_centideg, hdg_acc);
          errors++;
        end else begin
          want = expected_headings.pop_front();
          if (hdg_centideg !== want.heading) begin
            $display("%0t: heading mismatch: expected %0d actual %0d",
                     $time, want.heading, hdg_centideg);
            errors++;
          end
          if (hdg_acc !== want.acc) begin
            $display("%0t: accuracy mismatch: expected %0d actual %0d",
                     $time, want.acc, hdg_acc);
            errors++;
          end
        end
      end
      quiet_cycles <= (accepted || hdg_valid) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("quaternion_to_heading regression: fail");
        $finish;
      end
    end
  end

  task automatic add_report(input logic [7:0] rid, input logic signed [15:0] qr,
                            input logic signed [15:0] qi, input logic signed [15:0] qj,
                            input logic signed [15:0] qk, input logic [1:0] st);
    report_t rep;
    rep.rid = rid;
    rep.qr  = qr;
    rep.qi  = qi;
    rep.qj  = qj;
    rep.qk  = qk;
    rep.st  = st;
    pending_reports.push_back(rep);
  endtask

  // Random component: mostly Q14 range, sometimes any 16-bit value.
  function automatic logic signed [15:0] rand_comp(input bit wide);
    if (wide) return 16'($urandom_range(65535));
    return 16'($urandom_range(32768) - 16384);
  endfunction

  // n random reports: half unit quaternions, half raw random components;
  // most carry the configured id, the rest a foreign one.
  task automatic add_random(input int n);
    real    a, b, c, d, nrm;
    int     kind, sel;
    logic [7:0] rid;
    logic signed [15:0] qr, qi, qj, qk;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      sel  = $urandom_range(99);
      rid  = rotation_id;
      if (kind < 15) begin
        rid = 8'($urandom_range(255));
        // near misses are the interesting ones
        if (sel < 40) rid = rotation_id ^ (8'd1 << $urandom_range(7));
        if (rid == rotation_id) rid = ~rotation_id;
      end
      if (sel < 50) begin
        a = rand_comp(0);
        b = rand_comp(0);
        c = rand_comp(0);
        d = rand_comp(0);
        // yaw-only rotations now and then
        if (sel < 15) begin
          b = 0.0;
          c = 0.0;
        end
        nrm = $sqrt(a * a + b * b + c * c + d * d);
        if (nrm == 0.0) begin
          a   = 1.0;
          nrm = 1.0;
        end
        qr = 16'($rtoi(a / nrm * 16384.0));
        qi = 16'($rtoi(b / nrm * 16384.0));
        qj = 16'($rtoi(c / nrm * 16384.0));
        qk = 16'($rtoi(d / nrm * 16384.0));
      end else begin
        qr = rand_comp(sel >= 80);
        qi = rand_comp(sel >= 80);
        qj = rand_comp(sel >= 80);
        qk = rand_comp(sel >= 80);
      end
      add_report(rid, qr, qi, qj, qk, 2'($urandom_range(3)));
    end
  endtask

  // Block until every queued request is taken and every strobe has arrived,
  // then wait out the SETTLE margin.
  task automatic wait_idle();
    while (pending_reports.size() != 0 || req_start || expected_headings.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_rotation_id(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    rotation_id = v;
    @(negedge clk_i);
    cfg_we      <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed reports against the reset id.
    add_report(RID_RESET, 16384, 0, 0, 0, 3);            // identity -> 0
    add_report(RID_RESET, 0, 0, 0, 0, 0);                // zero vector
    add_report(RID_RESET, 0, 0, 0, 16384, 1);            // x < 0, y = 0 -> 180
    add_report(RID_RESET, 16384, 0, 0, -1, 2);           // just below zero: wraps
    add_report(RID_RESET, 16384, 0, 0, 1, 3);            // just above zero
    add_report(RID_RESET, 11585, 0, 0, 11585, 2);        // +90
    add_report(RID_RESET, 11585, 0, 0, -11585, 1);       // -90 -> 270
    add_report(RID_RESET, -16384, 0, 0, 0, 0);           // negated identity
    add_report(RID_RESET, -1, 0, 0, 16384, 3);           // x < 0, y < 0 near -180
    add_report(RID_RESET, 1, 0, 0, 16384, 2);            // x < 0, y > 0 near +180
    add_report(RID_RESET, -32768, -32768, -32768, -32768, 1);
    add_report(RID_RESET, 32767, 32767, 32767, 32767, 0);
    add_report(RID_RESET, 32767, -32768, 32767, -32768, 3);
    add_report(RID_RESET, -32768, 32767, 0, 32767, 2);
    add_report(RID_RESET, 0, 16384, 0, 0, 1);            // x > 0, y = 0
    add_report(RID_RESET, 0, 0, 16384, 0, 2);            // x < 0 from q_j
    add_report(RID_RESET, 0, 16384, 16384, 0, 3);        // x = 0, y > 0
    add_report(RID_RESET, 0, 16384, -16384, 0, 0);       // x = 0, y < 0
    add_report(RID_RESET, 30000, 0, 0, -20000, 1);       // beyond unit length
    add_report(RID_RESET - 8'd1, 16384, 0, 0, 0, 3);     // foreign ids: no result
    add_report(8'd0, 16384, 0, 0, 0, 2);
    add_report(8'd255, 16384, 0, 0, 0, 1);
    wait_idle();

    write_rotation_id(8'd0);
    add_random(300);
    wait_idle();

    // back-to-back requests for a whole phase
    write_rotation_id(8'd255);
    steady = 1'b1;
    add_random(300);
    wait_idle();
    steady = 1'b0;

    write_rotation_id(8'($urandom_range(255)));
    add_random(300);
    wait_idle();

    write_rotation_id(RID_RESET);
    add_random(300);
    wait_idle();

    if (errors == 0 && expected_headings.size() == 0) begin
      $display("quaternion_to_heading regression: pass");
    end else begin
      $display("quaternion_to_heading regression: fail");
    end
    $finish;
  end

endmodule
